// ===== rtl/i2cms_pkg.sv =====
// ---------------------------------------------------------------------------
// i2cms_pkg
// shared types, command codes and phase counts for the i2c bit sequencer
// ---------------------------------------------------------------------------
package i2cms_pkg;

   localparam int PhaseWidth = 16;
   localparam int StepWidth  = 6;

   localparam logic [2:0] MODE_START = 3'd0;
   localparam logic [2:0] MODE_STOP  = 3'd1;
   localparam logic [2:0] MODE_WRITE = 3'd2;
   localparam logic [2:0] MODE_READ  = 3'd3;
   localparam logic [2:0] MODE_WAIT  = 3'd4;

   localparam logic [PhaseWidth-1:0] PHASE_TICKS_RESET = 16'd500;

   typedef struct packed {
      logic       valid;
      logic [2:0] mode;
      logic [7:0] write_data;
      logic       send_ack;
   } cmd_type;

   typedef struct packed {
      logic       scl;
      logic       sda;
      logic       busy;
      logic       done;
      logic [7:0] read_data;
      logic       ack_seen;
   } line_status_type;

   function automatic logic [StepWidth-1:0] phase_total(input logic [2:0] mode);
      logic [StepWidth-1:0] total;
      case (mode)
         MODE_START: total = 6'd4;
         MODE_STOP:  total = 6'd3;
         MODE_WRITE: total = 6'd25;
         MODE_READ:  total = 6'd19;
         default:    total = 6'd3;
      endcase
      return total;
   endfunction

endpackage

// ===== rtl/i2cms_seq.sv =====
// ---------------------------------------------------------------------------
// i2cms_seq
// line phase sequencer: steps through the phases of one bus command, one phase count per tick
// ---------------------------------------------------------------------------
module i2cms_seq (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         advance,
   input  i2cms_pkg::cmd_type           cmd,
   input  logic                         sda_line,
   input  logic [i2cms_pkg::PhaseWidth-1:0] phase_ticks,
   output i2cms_pkg::line_status_type   status
);
   import i2cms_pkg::*;

   logic [StepWidth-1:0]  step_ff, step_in;
   logic [PhaseWidth-1:0] count_ff, count_in;
   logic [2:0]            mode_ff, mode_in;
   logic [7:0]            shift_ff, shift_in;
   logic [1:0]            sub_ff, sub_in;
   logic                  ackc_ff, ackc_in;
   logic                  scl_ff, scl_in;
   logic                  sda_ff, sda_in;
   logic                  ack_ff, ack_in;

   logic [StepWidth-1:0]  total;
   logic [StepWidth-1:0]  k;
   logic [StepWidth-1:0]  step_inc;
   logic [PhaseWidth:0]   plen;
   logic                  busy;
   logic                  done;
   logic                  enter;

   assign total    = phase_total(mode_ff);
   assign busy     = step_ff != '0;
   assign done     = busy && (step_ff > total);
   assign step_inc = step_ff + 6'd1;
   assign plen     = (phase_ticks == '0) ? 17'd1 : {1'b0, phase_ticks};

   always_comb begin
      step_in  = step_ff;
      count_in = count_ff;
      mode_in  = mode_ff;
      shift_in = shift_ff;
      sub_in   = sub_ff;
      ackc_in  = ackc_ff;
      scl_in   = scl_ff;
      sda_in   = sda_ff;
      ack_in   = ack_ff;
      enter    = 1'b0;
      k        = '0;

      if (advance) begin
         if (!busy) begin
            if (cmd.valid && cmd.mode <= MODE_WAIT) begin
               mode_in  = cmd.mode;
               shift_in = (cmd.mode == MODE_WRITE) ? cmd.write_data : 8'd0;
               ackc_in  = cmd.send_ack;
               count_in = '0;
               sub_in   = 2'd0;
               step_in  = 6'd1;
               enter    = 1'b1;
               k        = '0;
            end
         end else if (done) begin
            if (mode_ff == MODE_READ) begin
               sda_in = 1'b1;
            end
            step_in  = '0;
            count_in = '0;
         end else if ({1'b0, count_ff} + 17'd1 >= plen) begin
            // sample at the end of the phase
            if (mode_ff == MODE_READ && step_ff < 6'd17 && step_ff[0]) begin
               shift_in = {shift_ff[6:0], sda_line};
            end else if (mode_ff == MODE_WAIT && step_ff == 6'd2) begin
               ack_in = !sda_line;
            end
            step_in  = step_inc;
            count_in = '0;
            if (step_inc <= total) begin
               enter = 1'b1;
               k     = step_ff;
            end
         end else begin
            count_in = count_ff + 16'd1;
         end
      end

      if (enter) begin
         case (mode_in)
            MODE_START: begin
               if (k == 6'd0) sda_in = 1'b1;
               else if (k == 6'd1) scl_in = 1'b1;
               else if (k == 6'd2) sda_in = 1'b0;
               else scl_in = 1'b0;
            end
            MODE_STOP: begin
               if (k == 6'd0) sda_in = 1'b0;
               else if (k == 6'd1) scl_in = 1'b1;
               else sda_in = 1'b1;
            end
            MODE_WRITE: begin
               if (k >= 6'd24) begin
                  sda_in = 1'b1;
               end else begin
                  case (sub_in)
                     2'd0:    sda_in = shift_in[7];
                     2'd1:    scl_in = 1'b1;
                     default: begin
                        scl_in   = 1'b0;
                        shift_in = {shift_in[6:0], 1'b0};
                     end
                  endcase
                  sub_in = (sub_in == 2'd2) ? 2'd0 : sub_in + 2'd1;
               end
            end
            MODE_READ: begin
               if (k < 6'd16) begin
                  if (!k[0]) begin
                     scl_in = 1'b1;
                     if (k == 6'd0) sda_in = 1'b1;
                  end else begin
                     scl_in = 1'b0;
                  end
               end else if (k == 6'd16) begin
                  sda_in = !ackc_in;
               end else if (k == 6'd17) begin
                  scl_in = 1'b1;
               end else begin
                  scl_in = 1'b0;
               end
            end
            default: begin
               if (k == 6'd0) sda_in = 1'b1;
               else if (k == 6'd1) scl_in = 1'b1;
               else scl_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= '0;
         count_ff <= '0;
         mode_ff  <= MODE_START;
         shift_ff <= '0;
         sub_ff   <= '0;
         ackc_ff  <= 1'b0;
         scl_ff   <= 1'b1;
         sda_ff   <= 1'b1;
         ack_ff   <= 1'b0;
      end else begin
         step_ff  <= step_in;
         count_ff <= count_in;
         mode_ff  <= mode_in;
         shift_ff <= shift_in;
         sub_ff   <= sub_in;
         ackc_ff  <= ackc_in;
         scl_ff   <= scl_in;
         sda_ff   <= sda_in;
         ack_ff   <= ack_in;
      end
   end

   always_comb begin
      status.scl       = scl_ff;
      status.sda       = sda_ff;
      status.busy      = busy;
      status.done      = done;
      status.read_data = (done && mode_ff == MODE_READ) ? shift_ff : 8'd0;
      status.ack_seen  = ack_ff;
   end

endmodule

// ===== rtl/i2c_master_bit_sequencer_core.sv =====
// ---------------------------------------------------------------------------
// i2c_master_bit_sequencer_core
// i2c master line sequencer, one tick per transaction
// ---------------------------------------------------------------------------
// each req transaction is one bus tick: it may carry a command (start, stop,
// write byte, read byte, wait ack) and always carries the sampled sda level.
// commands are taken only while the sequencer is idle; otherwise ignored.
// each req transaction yields exactly one rsp transaction holding the line
// drives and status as they stood before that tick, so the sequencer runs
// only as fast as ticks are fed.
// the rsp transaction is registered and appears in the cycle after its req transaction.
// throughput: one transaction per cycle; the output register lets a new req
// transaction in while the previous rsp transaction is taken in the same
// cycle. when rsp is stalled, req_tready drops and the state holds.
// csr write sets phase_ticks (ticks per line phase, zero counts as one);
// write only while idle. reset releases both lines, clears the state and
// loads phase_ticks with 500; the csr port is always ready.
// ---------------------------------------------------------------------------
module i2c_master_bit_sequencer_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // write_data[7:0], send_ack[8], sda_in[9], zero
   input  logic [3:0]  req_tuser,  // cmd_valid[0], mode[3:1]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,  // scl_out, sda_out, busy_res, done_res,
                                   // read_data[11:4], ack_seen[12], zero
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_wdata
);
   import i2cms_pkg::*;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [15:0]           rsp_data_ff;
   logic [PhaseWidth-1:0] phase_ticks_ff;
   logic                  accept;
   cmd_type               cmd;
   line_status_type       status;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign cmd.valid      = req_tuser[0];
   assign cmd.mode       = req_tuser[3:1];
   assign cmd.write_data = req_tdata[7:0];
   assign cmd.send_ack   = req_tdata[8];

   i2cms_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .advance     (accept),
      .cmd         (cmd),
      .sda_line    (req_tdata[9]),
      .phase_ticks (phase_ticks_ff),
      .status      (status)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff   <= 1'b0;
         phase_ticks_ff <= PHASE_TICKS_RESET;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) phase_ticks_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= {3'd0, status.ack_seen, status.read_data, status.done,
                         status.busy, status.sda, status.scl};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== rtl/i2cms_checker.sv =====
// ---------------------------------------------------------------------------
// i2cms_checker
// port-level checks for the i2c bit sequencer
// ---------------------------------------------------------------------------
module i2cms_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);

   // no rsp transaction right after reset
   a_reset_quiet: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_tvalid)
      else $error("rsp valid after reset");

   // stalled rsp transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled rsp changed");

   // done tick only inside a busy command
   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[3] |-> rsp_tdata[2])
      else $error("done without busy");

   // read byte shown only on the done tick
   a_read_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[3] |-> rsp_tdata[11:4] == 8'd0)
      else $error("read data outside done");

   // empty output register never blocks input
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input blocked while output empty");

endmodule

bind i2c_master_bit_sequencer_core i2cms_checker u_i2cms_checker (.*);
